### hw/rtl/lodd_pkg.sv
`default_nettype none

package lodd_pkg;

  // Fixed field widths of the stream words
  localparam int unsigned IdInW    = 5;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned DepthOutW = 5;

  typedef enum logic [StatusW-1:0] {
    ST_OK           = 3'd0,
    ST_POP_EMPTY    = 3'd1,
    ST_POP_MISMATCH = 3'd2,
    ST_DEADLOCK     = 3'd3,
    ST_HALTED       = 3'd4,
    ST_FULL         = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_STACK,
    FSM_ROW,
    FSM_SEARCH,
    FSM_RESULT
  } fsm_e;

  // Answer of the reachability search
  typedef struct packed {
    logic done;
    logic found;
  } reach_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/lock_order_deadlock_detector.sv
`default_nettype none

// Lock-order deadlock detector. Each input word is one acquire (tuser 0) or
// release (tuser 1) of a lock id; each gives exactly one output word with a
// status and the number of locks held afterwards. Ids at or above LOCK_COUNT
// wrap modulo LOCK_COUNT. The held stack lives in a memory with one read and
// one write port, the lock-order graph in a memory of LOCK_COUNT adjacency
// rows with a valid bit per row, so reset clears it at once and no clearing
// pass is needed. An item is accepted, then the top of the stack is read,
// then the row of the top lock, and then the result is handed over; steps
// that an item does not need are skipped. A new edge starts a reachability
// search that sweeps the rows one per cycle through the single read port of
// the graph memory, pass after pass until the top lock is reached or a pass
// finds nothing new; it needs one more pass than the longest chain of back
// edges in the sweep order, at most LOCK_COUNT. After a deadlock every
// item answers halted until reset.
module lock_order_deadlock_detector import lodd_pkg::*; #(
  parameter int unsigned LOCK_COUNT  = 32,
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [4:0] lock_id
  input  wire logic [0:0] s_axis_tuser,   // [0] req_type
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic      [7:0] m_axis_tdata    // [2:0] status, [7:3] stack_depth
);

  localparam int unsigned IdW = $clog2(LOCK_COUNT);
  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SaW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned IdCodes = 2 ** IdInW;

  fsm_e            state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            halted_q, halted_d;
  logic            rel_q, rel_d;
  logic [IdW-1:0]  id_q, id_d;
  logic [IdW-1:0]  top_q, top_d;
  status_e         res_q, res_d;

  logic                 out_vld_q;
  status_e              out_status_q;
  logic [DepthOutW-1:0] out_depth_q;
  logic                 load;

  logic            in_acc;
  logic [IdW-1:0]  id_map;
  logic [CntW-1:0] cnt_m1;

  logic            stk_rd_en, stk_wr_en;
  logic [SaW-1:0]  stk_rd_addr;
  logic [IdW-1:0]  stk_rd_data, stk_wr_data;

  logic                  fsm_rd_en, edge_rd_en, edge_wr_en;
  logic [IdW-1:0]        fsm_rd_addr, edge_rd_addr;
  logic [LOCK_COUNT-1:0] edge_rd_data, edge_wr_data;

  logic            reach_start, reach_rd_en;
  logic [IdW-1:0]  reach_rd_addr;
  reach_rsp_t      reach_rsp;

  // Wrap incoming ids into range
  logic [IdW-1:0] id_lut [IdCodes];
  for (genvar g = 0; g < IdCodes; g++) begin : g_id_lut
    assign id_lut[g] = IdW'(g % LOCK_COUNT);
  end
  assign id_map = id_lut[s_axis_tdata[IdInW-1:0]];

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign cnt_m1 = cnt_q - CntW'(1);

  // Memories and search unit
  lodd_stack_mem #(
    .STACK_DEPTH(STACK_DEPTH),
    .ID_W       (IdW)
  ) u_stack (
    .clk_i    (clk_i),
    .rd_en_i  (stk_rd_en),
    .rd_addr_i(stk_rd_addr),
    .rd_data_o(stk_rd_data),
    .wr_en_i  (stk_wr_en),
    .wr_addr_i(cnt_q[SaW-1:0]),
    .wr_data_i(stk_wr_data)
  );

  assign edge_rd_en   = fsm_rd_en | reach_rd_en;
  assign edge_rd_addr = reach_rd_en ? reach_rd_addr : fsm_rd_addr;
  assign edge_wr_data = edge_rd_data | (LOCK_COUNT'(1) << id_q);

  lodd_edge_mem #(
    .LOCK_COUNT(LOCK_COUNT)
  ) u_edges (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (edge_rd_en),
    .rd_addr_i(edge_rd_addr),
    .rd_data_o(edge_rd_data),
    .wr_en_i  (edge_wr_en),
    .wr_addr_i(top_q),
    .wr_data_i(edge_wr_data)
  );

  lodd_reach #(
    .LOCK_COUNT(LOCK_COUNT)
  ) u_reach (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (reach_start),
    .src_i    (id_q),
    .dst_i    (top_q),
    .rd_en_o  (reach_rd_en),
    .rd_addr_o(reach_rd_addr),
    .row_i    (edge_rd_data),
    .rsp_o    (reach_rsp)
  );

  // Sequencer: next state and memory commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    halted_d    = halted_q;
    rel_d       = rel_q;
    id_d        = id_q;
    top_d       = top_q;
    res_d       = res_q;
    s_axis_tready = 1'b0;
    stk_rd_en   = 1'b0;
    stk_rd_addr = cnt_m1[SaW-1:0];
    stk_wr_en   = 1'b0;
    stk_wr_data = id_q;
    fsm_rd_en   = 1'b0;
    fsm_rd_addr = stk_rd_data;
    edge_wr_en  = 1'b0;
    reach_start = 1'b0;
    load        = 1'b0;
    case (state_q)
      FSM_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_acc) begin
          rel_d = s_axis_tuser[0];
          id_d  = id_map;
          state_d = FSM_RESULT;
          if (halted_q) begin
            res_d = ST_HALTED;
          end else if (s_axis_tuser[0]) begin
            if (cnt_q == '0) begin
              res_d = ST_POP_EMPTY;
            end else begin
              stk_rd_en = 1'b1;
              state_d   = FSM_STACK;
            end
          end else if (cnt_q == CntW'(STACK_DEPTH)) begin
            res_d = ST_FULL;
          end else if (cnt_q == '0) begin
            // first lock: nothing to order against
            stk_wr_en   = 1'b1;
            stk_wr_data = id_map;
            cnt_d       = cnt_q + CntW'(1);
            res_d       = ST_OK;
          end else begin
            stk_rd_en = 1'b1;
            state_d   = FSM_STACK;
          end
        end
      end
      FSM_STACK: begin
        top_d   = stk_rd_data;
        state_d = FSM_RESULT;
        res_d   = ST_OK;
        if (rel_q) begin
          if (stk_rd_data == id_q) begin
            cnt_d = cnt_m1;
          end else begin
            res_d = ST_POP_MISMATCH;
          end
        end else if (stk_rd_data == id_q) begin
          // same lock again: no edge, push once more
          stk_wr_en = 1'b1;
          cnt_d     = cnt_q + CntW'(1);
        end else begin
          fsm_rd_en = 1'b1;
          state_d   = FSM_ROW;
        end
      end
      FSM_ROW: begin
        if (edge_rd_data[id_q]) begin
          stk_wr_en = 1'b1;
          cnt_d     = cnt_q + CntW'(1);
          res_d     = ST_OK;
          state_d   = FSM_RESULT;
        end else begin
          // new edge: record it, then look for a path back to the top
          edge_wr_en  = 1'b1;
          reach_start = 1'b1;
          state_d     = FSM_SEARCH;
        end
      end
      FSM_SEARCH: begin
        if (reach_rsp.done) begin
          state_d = FSM_RESULT;
          if (reach_rsp.found) begin
            halted_d = 1'b1;
            res_d    = ST_DEADLOCK;
          end else begin
            stk_wr_en = 1'b1;
            cnt_d     = cnt_q + CntW'(1);
            res_d     = ST_OK;
          end
        end
      end
      FSM_RESULT: begin
        if (!out_vld_q || m_axis_tready) begin
          load    = 1'b1;
          state_d = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FSM_IDLE;
      cnt_q     <= '0;
      halted_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      halted_q <= halted_d;
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Item payload and output word
  always_ff @(posedge clk_i) begin
    rel_q <= rel_d;
    id_q  <= id_d;
    top_q <= top_d;
    res_q <= res_d;
    if (load) begin
      out_status_q <= res_q;
      out_depth_q  <= DepthOutW'(cnt_q);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_depth_q, out_status_q};

  // Checks
  a_done_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reach_rsp.done |-> state_q == FSM_SEARCH)
    else $error("search finished outside the search state");

  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt cleared without reset");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(STACK_DEPTH))
    else $error("held count beyond stack depth");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_wr_en |-> !(edge_rd_en && (edge_rd_addr == top_q)))
    else $error("graph row read while being written");

endmodule

`default_nettype wire

### hw/rtl/lodd_edge_mem.sv
`default_nettype none

module lodd_edge_mem #(
  parameter int unsigned LOCK_COUNT = 32,
  localparam int unsigned IdW = $clog2(LOCK_COUNT)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  rd_en_i,
  input  wire logic [IdW-1:0]        rd_addr_i,
  output logic      [LOCK_COUNT-1:0] rd_data_o,
  input  wire logic                  wr_en_i,
  input  wire logic [IdW-1:0]        wr_addr_i,
  input  wire logic [LOCK_COUNT-1:0] wr_data_i
);

  logic [LOCK_COUNT-1:0] mem_q [LOCK_COUNT];
  logic [LOCK_COUNT-1:0] row_q;
  logic [LOCK_COUNT-1:0] vld_q;
  logic                  hit_q;

  // Row storage and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      row_q <= mem_q[rd_addr_i];
    end
  end

  // Row valid bits: a row never written reads as no edges
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      hit_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        hit_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = hit_q ? row_q : '0;

endmodule

`default_nettype wire

### hw/rtl/lodd_stack_mem.sv
`default_nettype none

module lodd_stack_mem #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned ID_W = 5,
  localparam int unsigned SaW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            rd_en_i,
  input  wire logic [SaW-1:0]  rd_addr_i,
  output logic      [ID_W-1:0] rd_data_o,
  input  wire logic            wr_en_i,
  input  wire logic [SaW-1:0]  wr_addr_i,
  input  wire logic [ID_W-1:0] wr_data_i
);

  logic [ID_W-1:0] mem_q [STACK_DEPTH];
  logic [ID_W-1:0] rd_q;

  // Held ids, one port each way, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

### hw/rtl/lodd_reach.sv
`default_nettype none

module lodd_reach import lodd_pkg::*; #(
  parameter int unsigned LOCK_COUNT = 32,
  localparam int unsigned IdW = $clog2(LOCK_COUNT),
  localparam int unsigned IsW = $clog2(LOCK_COUNT + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [IdW-1:0]        src_i,
  input  wire logic [IdW-1:0]        dst_i,
  output logic                       rd_en_o,
  output logic      [IdW-1:0]        rd_addr_o,
  input  wire logic [LOCK_COUNT-1:0] row_i,
  output reach_rsp_t                 rsp_o
);

  logic                  busy_q;
  logic [LOCK_COUNT-1:0] vis_q;
  logic [LOCK_COUNT-1:0] exp_q;
  logic                  chg_q;
  logic [IsW-1:0]        iss_q;
  logic                  pv_q;
  logic [IdW-1:0]        pu_q;
  logic [IdW-1:0]        dst_q;

  logic                  issue;
  logic                  pend;
  logic                  last;
  logic                  chg_any;
  logic [LOCK_COUNT-1:0] new_bits;

  // Sweep over all rows; expand each visited, unexpanded row once
  always_comb begin
    issue     = busy_q && (iss_q < IsW'(LOCK_COUNT));
    rd_en_o   = issue;
    rd_addr_o = iss_q[IdW-1:0];
    pend      = pv_q && vis_q[pu_q] && !exp_q[pu_q];
    new_bits  = pend ? (row_i & ~vis_q) : '0;
    last      = pv_q && (pu_q == IdW'(LOCK_COUNT - 1));
    chg_any   = chg_q || (new_bits != '0);
    // done on a hit, or at the end of a pass that found nothing new
    rsp_o.found = vis_q[dst_q];
    rsp_o.done  = busy_q && (vis_q[dst_q] || (last && !chg_any));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      vis_q  <= '0;
      exp_q  <= '0;
      chg_q  <= 1'b0;
      iss_q  <= '0;
      pv_q   <= 1'b0;
      pu_q   <= '0;
      dst_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      vis_q  <= LOCK_COUNT'(1) << src_i;
      exp_q  <= '0;
      chg_q  <= 1'b0;
      iss_q  <= '0;
      pv_q   <= 1'b0;
      dst_q  <= dst_i;
    end else if (busy_q) begin
      if (rsp_o.done) begin
        busy_q <= 1'b0;
        pv_q   <= 1'b0;
      end else begin
        vis_q <= vis_q | new_bits;
        if (pend) begin
          exp_q[pu_q] <= 1'b1;
        end
        pv_q <= issue;
        pu_q <= iss_q[IdW-1:0];
        if (issue) begin
          iss_q <= iss_q + IsW'(1);
        end else if (last) begin
          iss_q <= '0;
        end
        chg_q <= last ? 1'b0 : chg_any;
      end
    end
  end

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lodd_pkg::*;

  localparam int LOCKS     = 32;
  localparam int STACK_MAX = 16;
  localparam int CYCLE_CAP = 20_000_000;
  localparam int HOLD_LEN  = 300;
  localparam int PHASE_LEN = 633;

  typedef struct packed {
    status_e    status;
    logic [4:0] depth;
  } lock_word_t;

  // One row of directed stimulus; typed rows carry their own answer
  typedef struct {
    bit         rel;
    logic [4:0] id;
    bit         typed;
    status_e    status;
    logic [4:0] depth;
  } event_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;    // [4:0] lock_id
  logic [0:0] s_axis_tuser = 1'b0;     // [0] req_type
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;            // [2:0] status, [7:3] stack_depth

  // Shadow of the lock-order graph, the held stack and the halt
  logic [LOCKS-1:0] order_graph [LOCKS] = '{default: '0};
  logic [4:0]       held_ids [STACK_MAX];
  int               held_num = 0;
  bit               halted = 1'b0;

  lock_word_t pending_words [$];
  int         lock_rank [LOCKS];
  int         mismatches = 0;
  int         cycles = 0;
  int         send_idle_pct = 11;
  int         recv_idle_pct = 51;
  int         acq_bias = 50;
  int         hold_req = 0;
  int         hold_seen = 0;
  int         hold_left = 0;

  event_row_t head_rows [21];
  event_row_t tail_rows [5];

  lock_order_deadlock_detector DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Breadth-first sweep: true when dst is reachable from src
  function automatic bit lock_reaches(int src, int dst);
    logic [LOCKS-1:0] seen;
    logic [LOCKS-1:0] frontier;
    logic [LOCKS-1:0] grow;
    seen = '0;
    seen[src] = 1'b1;
    frontier = seen;
    while (frontier != '0) begin
      grow = '0;
      for (int u = 0; u < LOCKS; u++) begin
        if (frontier[u]) grow |= order_graph[u];
      end
      frontier = grow & ~seen;
      seen |= grow;
    end
    return seen[dst];
  endfunction

  // True when acquiring id now would close a cycle in the graph
  function automatic bit closes_cycle(logic [4:0] id);
    logic [4:0] top;
    if (halted || held_num == 0 || held_num >= STACK_MAX) return 1'b0;
    top = held_ids[held_num-1];
    return top != id && !order_graph[top][id] && lock_reaches(id, top);
  endfunction

  // Advance the shadow state by one lock event and give its answer
  task automatic apply_lock_event(input bit rel, input logic [4:0] id,
                                  output status_e st, output logic [4:0] depth);
    logic [4:0] top;
    st = ST_OK;
    if (halted) begin
      st = ST_HALTED;
    end else if (rel) begin
      if (held_num == 0) st = ST_POP_EMPTY;
      else if (held_ids[held_num-1] != id) st = ST_POP_MISMATCH;
      else held_num--;
    end else if (held_num >= STACK_MAX) begin
      st = ST_FULL;
    end else begin
      if (held_num > 0) begin
        top = held_ids[held_num-1];
        if (top != id && !order_graph[top][id]) begin
          order_graph[top][id] = 1'b1;
          if (lock_reaches(id, top)) begin
            st = ST_DEADLOCK;
            halted = 1'b1;
          end
        end
      end
      if (st == ST_OK) begin
        held_ids[held_num] = id;
        held_num++;
      end
    end
    depth = 5'(held_num);
  endtask

  // Offer one word, wait for it to be taken, then queue its answer
  task automatic send_lock_event(input bit rel, input logic [4:0] id, input bit typed,
                                 input status_e st_t, input logic [4:0] depth_t);
    status_e    st;
    logic [4:0] depth;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, id};
    s_axis_tuser  <= rel;
    do @(posedge clk_i); while (!s_axis_tready);
    apply_lock_event(rel, id, st, depth);
    if (typed) begin
      st = st_t;
      depth = depth_t;
    end
    pending_words.push_back('{st, depth});
    @(negedge clk_i);
  endtask

  // Mostly nested acquires in rank order and matching releases, some noise;
  // an acquire that would deadlock is turned into a (mismatched) release
  task automatic pick_lock_event(output bit rel, output logic [4:0] id);
    logic [4:0] top;
    int         cands [$];
    if ($urandom_range(99) < 22) begin
      rel = 1'($urandom_range(1));
      id  = 5'($urandom_range(LOCKS - 1));
    end else if (held_num == 0) begin
      rel = 1'b0;
      id  = 5'($urandom_range(LOCKS - 1));
    end else begin
      top = held_ids[held_num-1];
      if ($urandom_range(99) < acq_bias) begin
        rel = 1'b0;
        id  = top;
        if ($urandom_range(99) >= 20) begin
          for (int k = 0; k < LOCKS; k++) begin
            if (lock_rank[k] > lock_rank[top]) cands.push_back(k);
          end
          if (cands.size() != 0) id = 5'(cands[$urandom_range(cands.size() - 1)]);
        end
      end else begin
        rel = 1'b1;
        id  = top;
      end
    end
    if (!rel && closes_cycle(id)) rel = 1'b1;
  endtask

  task automatic run_random(input int count);
    bit         rel;
    logic [4:0] id;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) acq_bias = $urandom_range(85, 25);
      pick_lock_event(rel, id);
      send_lock_event(rel, id, 1'b0, ST_OK, 5'd0);
    end
  endtask

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0d: %s expected %0d got %0d", mismatches, what, want, got);
  endtask

  // Reset, then stimulus phases, then the final check
  initial begin
    int j;
    int tmp;
    head_rows = '{
      '{1'b1, 5'd0,  1'b1, ST_POP_EMPTY,    5'd0},
      '{1'b1, 5'd31, 1'b1, ST_POP_EMPTY,    5'd0},
      '{1'b0, 5'd0,  1'b1, ST_OK,           5'd1},
      '{1'b1, 5'd31, 1'b1, ST_POP_MISMATCH, 5'd1},
      '{1'b0, 5'd31, 1'b1, ST_OK,           5'd2},
      '{1'b0, 5'd31, 1'b1, ST_OK,           5'd3},
      '{1'b0, 5'd31, 1'b1, ST_OK,           5'd4},
      '{1'b0, 5'd31, 1'b1, ST_OK,           5'd5},
      '{1'b0, 5'd31, 1'b1, ST_OK,           5'd6},
      '{1'b0, 5'd31, 1'b1, ST_OK,           5'd7},
      '{1'b0, 5'd31, 1'b1, ST_OK,           5'd8},
      '{1'b0, 5'd31, 1'b1, ST_OK,           5'd9},
      '{1'b0, 5'd31, 1'b1, ST_OK,           5'd10},
      '{1'b0, 5'd31, 1'b1, ST_OK,           5'd11},
      '{1'b0, 5'd31, 1'b1, ST_OK,           5'd12},
      '{1'b0, 5'd31, 1'b1, ST_OK,           5'd13},
      '{1'b0, 5'd31, 1'b1, ST_OK,           5'd14},
      '{1'b0, 5'd31, 1'b1, ST_OK,           5'd15},
      '{1'b0, 5'd31, 1'b1, ST_OK,           5'd16},
      '{1'b0, 5'd31, 1'b1, ST_FULL,         5'd16},
      '{1'b0, 5'd1,  1'b1, ST_FULL,         5'd16}
    };
    // Edge 0->31 is recorded above, so 31 then 0 must close a cycle
    tail_rows = '{
      '{1'b0, 5'd31, 1'b1, ST_OK,       5'd1},
      '{1'b0, 5'd0,  1'b1, ST_DEADLOCK, 5'd1},
      '{1'b0, 5'd5,  1'b1, ST_HALTED,   5'd1},
      '{1'b1, 5'd0,  1'b1, ST_HALTED,   5'd1},
      '{1'b1, 5'd31, 1'b1, ST_HALTED,   5'd1}
    };
    // Random global lock order for the well-formed sequences
    for (int k = 0; k < LOCKS; k++) lock_rank[k] = k;
    for (int k = LOCKS - 1; k > 0; k--) begin
      j = $urandom_range(k);
      tmp = lock_rank[k];
      lock_rank[k] = lock_rank[j];
      lock_rank[j] = tmp;
    end

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Phase 1: sender idles lightly, receiver heavily
    foreach (head_rows[i])
      send_lock_event(head_rows[i].rel, head_rows[i].id, head_rows[i].typed,
                      head_rows[i].status, head_rows[i].depth);
    run_random(PHASE_LEN - 20);

    // Phase 2: roles swapped, starting with a long receiver hold-off
    send_idle_pct = 51;
    recv_idle_pct <= 11;
    hold_req <= hold_req + 1;
    run_random(PHASE_LEN);

    // Sender pauses until the block has drained
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);

    // Phase 3: no idling
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    run_random(PHASE_LEN);

    // Empty the stack, then deadlock and the halted state
    while (held_num > 0)
      send_lock_event(1'b1, held_ids[held_num-1], 1'b0, ST_OK, 5'd0);
    foreach (tail_rows[i])
      send_lock_event(tail_rows[i].rel, tail_rows[i].id, tail_rows[i].typed,
                      tail_rows[i].status, tail_rows[i].depth);

    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Receiver ready, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each output word with the oldest expected answer
  always @(posedge clk_i) begin
    lock_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        note_mismatch("unexpected word, data", -1, int'(m_axis_tdata));
      end else begin
        want = pending_words.pop_front();
        if (m_axis_tdata[2:0] !== want.status)
          note_mismatch("status", int'(want.status), int'(m_axis_tdata[2:0]));
        if (m_axis_tdata[7:3] !== want.depth)
          note_mismatch("stack depth", int'(want.depth), int'(m_axis_tdata[7:3]));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule

### sim.f
hw/rtl/lodd_pkg.sv
hw/rtl/lodd_edge_mem.sv
hw/rtl/lodd_stack_mem.sv
hw/rtl/lodd_reach.sv
hw/rtl/lock_order_deadlock_detector.sv
tb/testbench.sv
